FILE: hdl/gfsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfsr_pkg
// Shared types and constants of the four-tap GFSR generator.
// ----------------------------------------------------------------------------
package gfsr_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned SEED_W = 64;

    // Feedback lags, counted back from the new index
    localparam int unsigned LAG_A = 471;
    localparam int unsigned LAG_B = 1586;
    localparam int unsigned LAG_C = 6988;
    localparam int unsigned LAG_D = 9689;

    // Congruential fill
    localparam logic [WORD_W-1:0] LCG_MUL       = 32'd69069;
    localparam logic [WORD_W-1:0] ZERO_SEED_SUB = 32'd4357;
    localparam logic [WORD_W-1:0] ALL_ONES      = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] TOP_BIT       = 32'h8000_0000;

    // Forced diagonal: word DIAG_START + DIAG_STEP*i, i below DIAG_COUNT
    localparam int unsigned DIAG_START = 7;
    localparam int unsigned DIAG_STEP  = 3;
    localparam int unsigned DIAG_COUNT = 32;

    // Index after a reseed
    localparam int unsigned SEED_INDEX = 32;

    // Request kinds
    localparam logic KIND_SEED = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ_CD,
        ST_FINISH,
        ST_SEED
    } gfsr_state_t;

endpackage : gfsr_pkg
`default_nettype wire

FILE: hdl/four_tap_gfsr_generator_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// four_tap_gfsr_generator_core
// Four-tap GFSR random generator over a table of 32-bit words in one RAM.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload
//  -------   --------------------   ------------------------
//  request   req_valid / req_stall  kind, seed_value
//  result    res_valid / res_stall  random_word (draws only)
//
//  A draw: the accepting cycle issues reads of the lags 471 and 1586, the
//  next issues reads of 6988 and 9689, then the write-back state writes the
//  new word back and loads the result register. The RAM has two read ports,
//  so the lags are read as two pairs. The write-back state holds while the
//  result register is full and stalled.
//  A reseed: the accepting cycle, then one congruential step per cycle, one
//  multiplier, each step shifting its top bit into the table word being built.
//  Reset clears the index and all control; the table holds nothing valid
//  until the first reseed, and there is no clearing pass.
//
module four_tap_gfsr_generator_core
    import gfsr_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 16384
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output      logic              req_stall,
    input  wire logic              kind,
    input  wire logic [SEED_W-1:0] seed_value,
    output      logic              res_valid,
    input  wire logic              res_stall,
    output      logic [WORD_W-1:0] random_word
);

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

    // Control and payload registers
    gfsr_state_t       state_reg,       state_next;
    logic [IDX_W-1:0]  idx_reg,         idx_next;
    logic [WORD_W-1:0] ab_reg,          ab_next;
    logic              res_valid_reg,   res_valid_next;
    logic [WORD_W-1:0] random_word_reg, random_word_next;

    // Request decode
    logic req_accept;
    logic draw_go;
    logic seed_go;

    // Table access
    logic [IDX_W-1:0]  idx_inc;
    logic [IDX_W-1:0]  rd_base;
    logic [IDX_W-1:0]  rd_addr_a;
    logic [IDX_W-1:0]  rd_addr_b;
    logic [WORD_W-1:0] rd_data_a;
    logic [WORD_W-1:0] rd_data_b;
    logic              ram_wr_en;
    logic [IDX_W-1:0]  ram_wr_addr;
    logic [WORD_W-1:0] ram_wr_data;
    logic [WORD_W-1:0] draw_word;
    logic              draw_wr;
    logic              res_free;

    // Filler
    logic              seed_wr_en;
    logic [IDX_W-1:0]  seed_wr_addr;
    logic [WORD_W-1:0] seed_wr_data;
    logic              seed_done;

    assign req_accept = req_valid && !req_stall;
    assign draw_go    = req_accept && (kind == KIND_DRAW);
    assign seed_go    = req_accept && (kind == KIND_SEED);

    // The index advances on acceptance, so in the accepting cycle the base
    // is the incremented index and afterwards the register itself.
    assign idx_inc   = idx_reg + 1'b1;
    assign rd_base   = (state_reg == ST_IDLE) ? idx_inc : idx_reg;
    assign rd_addr_a = (state_reg == ST_IDLE) ? IDX_W'(rd_base - IDX_W'(LAG_A))
                                              : IDX_W'(rd_base - IDX_W'(LAG_C));
    assign rd_addr_b = (state_reg == ST_IDLE) ? IDX_W'(rd_base - IDX_W'(LAG_B))
                                              : IDX_W'(rd_base - IDX_W'(LAG_D));

    // Lags are all far larger than the draw length, so no write of a draw
    // ever lands on a word that a later draw is still reading: no forwarding.
    assign draw_word = ab_reg ^ rd_data_a ^ rd_data_b;
    assign res_free  = !res_valid_reg || !res_stall;

    gfsr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk       (clk),
        .wr_en     (ram_wr_en),
        .wr_addr   (ram_wr_addr),
        .wr_data   (ram_wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    gfsr_seed #(
        .ADDR_W (IDX_W)
    ) u_seed (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (seed_go),
        .seed    (seed_value),
        .wr_en   (seed_wr_en),
        .wr_addr (seed_wr_addr),
        .wr_data (seed_wr_data),
        .done    (seed_done)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (draw_go)
                begin
                    state_next = ST_READ_CD;
                end
                else if (seed_go)
                begin
                    state_next = ST_SEED;
                end
            end
            ST_READ_CD:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // hold until the result register can take the word
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEED:
            begin
                if (seed_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        req_stall   = 1'b1;
        draw_wr     = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg;
        ram_wr_data = draw_word;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
            end
            ST_READ_CD:
            begin
                req_stall = 1'b1;
            end
            ST_FINISH:
            begin
                draw_wr   = res_free;
                ram_wr_en = res_free;
            end
            ST_SEED:
            begin
                ram_wr_en   = seed_wr_en;
                ram_wr_addr = seed_wr_addr;
                ram_wr_data = seed_wr_data;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        idx_next         = idx_reg;
        ab_next          = ab_reg;
        res_valid_next   = res_valid_reg;
        random_word_next = random_word_reg;
        if (draw_go)
        begin
            idx_next = idx_inc;
        end
        else if (seed_done)
        begin
            idx_next = IDX_W'(SEED_INDEX);
        end
        if (state_reg == ST_READ_CD)
        begin
            ab_next = rd_data_a ^ rd_data_b;
        end
        if (draw_wr)
        begin
            res_valid_next   = 1'b1;
            random_word_next = draw_word;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ab_reg          <= ab_next;
        random_word_reg <= random_word_next;
    end

    assign res_valid   = res_valid_reg;
    assign random_word = random_word_reg;

`ifndef NO_ASSERTIONS
    // An accepted draw always moves on to the second read pair
    a_draw_sequence: assert property (@(posedge clk) disable iff (!rst_n)
        draw_go |=> (state_reg == ST_READ_CD))
        else $error("draw did not advance to second read");

    // A result appears only out of the write-back cycle
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside write-back");

    // Filler writes only while reseeding
    a_seed_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
        seed_wr_en |-> (state_reg == ST_SEED))
        else $error("filler write outside reseed");

    // Reseed leaves the index at its start position
    a_seed_index: assert property (@(posedge clk) disable iff (!rst_n)
        seed_done |=> (idx_reg == IDX_W'(SEED_INDEX)))
        else $error("index wrong after reseed");
`endif

endmodule : four_tap_gfsr_generator_core
`default_nettype wire

FILE: hdl/gfsr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfsr_ram
// Generic synchronous RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module gfsr_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output      logic [WIDTH-1:0]         rd_data_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output      logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule : gfsr_ram
`default_nettype wire

FILE: hdl/gfsr_seed.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfsr_seed
// Table filler: one congruential step per cycle, its top bit shifted into
// the word; forced diagonal applied on the fly as affected words are written.
// ----------------------------------------------------------------------------
module gfsr_seed
    import gfsr_pkg::*;
#(
    parameter int unsigned ADDR_W = 14
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [SEED_W-1:0] seed,
    output      logic              wr_en,
    output      logic [ADDR_W-1:0] wr_addr,
    output      logic [WORD_W-1:0] wr_data,
    output      logic              done
);

    logic              busy_reg,      busy_next;
    logic [WORD_W-1:0] lcg_reg,       lcg_next;
    logic [WORD_W-1:0] word_reg,      word_next;
    logic [4:0]        bit_cnt_reg,   bit_cnt_next;
    logic [ADDR_W-1:0] fill_addr_reg, fill_addr_next;
    logic [ADDR_W-1:0] diag_addr_reg, diag_addr_next;
    logic [5:0]        diag_cnt_reg,  diag_cnt_next;

    logic [WORD_W-1:0] lcg_step;
    logic [WORD_W-1:0] word_full;
    logic [WORD_W-1:0] keep_mask;
    logic [WORD_W-1:0] top_mask;
    logic              diag_hit;

    assign lcg_step  = lcg_reg * LCG_MUL;
    assign word_full = {word_reg[WORD_W-2:0], lcg_step[WORD_W-1]};
    assign keep_mask = ALL_ONES >> diag_cnt_reg[4:0];
    assign top_mask  = TOP_BIT >> diag_cnt_reg[4:0];

    assign wr_en    = busy_reg && (&bit_cnt_reg);
    assign wr_addr  = fill_addr_reg;
    assign diag_hit = wr_en && (diag_cnt_reg < 6'(DIAG_COUNT))
                      && (fill_addr_reg == diag_addr_reg);
    assign wr_data  = diag_hit ? ((word_full & keep_mask) | top_mask) : word_full;
    assign done     = wr_en && (&fill_addr_reg);

    always_comb
    begin
        busy_next      = busy_reg;
        lcg_next       = lcg_reg;
        word_next      = word_reg;
        bit_cnt_next   = bit_cnt_reg;
        fill_addr_next = fill_addr_reg;
        diag_addr_next = diag_addr_reg;
        diag_cnt_next  = diag_cnt_reg;
        if (start)
        begin
            busy_next      = 1'b1;
            lcg_next       = (seed == '0) ? ZERO_SEED_SUB : seed[WORD_W-1:0];
            bit_cnt_next   = '0;
            fill_addr_next = '0;
            diag_addr_next = ADDR_W'(DIAG_START);
            diag_cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            lcg_next     = lcg_step;
            word_next    = word_full;
            bit_cnt_next = bit_cnt_reg + 5'd1;
            if (wr_en)
            begin
                fill_addr_next = fill_addr_reg + 1'b1;
            end
            if (diag_hit)
            begin
                diag_addr_next = diag_addr_reg + ADDR_W'(DIAG_STEP);
                diag_cnt_next  = diag_cnt_reg + 6'd1;
            end
            if (done)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            bit_cnt_reg   <= '0;
            fill_addr_reg <= '0;
            diag_addr_reg <= '0;
            diag_cnt_reg  <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            bit_cnt_reg   <= bit_cnt_next;
            fill_addr_reg <= fill_addr_next;
            diag_addr_reg <= diag_addr_next;
            diag_cnt_reg  <= diag_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lcg_reg  <= lcg_next;
        word_reg <= word_next;
    end

endmodule : gfsr_seed
`default_nettype wire
